FILE: rtl/spcd_pkg.sv
// Shared types, constants and helpers for the spectral peak cluster detector.
package spcd_pkg;

    // Frame and field sizes
    localparam int DEF_FRAME_BINS = 4096;
    localparam int SAMPLE_W       = 16;
    localparam int BIN_OUT_W      = 12;
    localparam int GAP_W          = 8;
    localparam int MARGIN_W       = 15;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_LEVEL_THRESHOLD = 2'd0,
        REG_GAP_BINS        = 2'd1,
        REG_MIN_MARGIN      = 2'd2
    } t_reg_idx;

    localparam logic signed [SAMPLE_W-1:0] RST_LEVEL_THRESHOLD = -16'sd8960;
    localparam logic [GAP_W-1:0]           RST_GAP_BINS        = 8'd10;
    localparam logic [MARGIN_W-1:0]        RST_MIN_MARGIN      = 15'd1280;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_db;
        logic                       frame_end;
    } t_spcd_in;

    typedef struct packed {
        logic [BIN_OUT_W-1:0]       peak_bin;
        logic signed [SAMPLE_W-1:0] peak_level;
        logic [BIN_OUT_W-1:0]       first_bin;
        logic [BIN_OUT_W-1:0]       final_bin;
        logic                       run_last;
    } t_spcd_out;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level_threshold;
        logic [GAP_W-1:0]           gap_bins;
        logic [MARGIN_W-1:0]        min_margin;
    } t_spcd_cfg;

    // Results produced by one item, packed from slot 0
    typedef struct packed {
        logic [1:0] count;
        t_spcd_out  slot0;
        t_spcd_out  slot1;
    } t_spcd_push;

    // Peak minus threshold reaches the margin
    function automatic logic margin_ok(
        input logic signed [SAMPLE_W-1:0] level,
        input logic signed [SAMPLE_W-1:0] thr,
        input logic [MARGIN_W-1:0]        margin
    );
        logic signed [SAMPLE_W+1:0] diff;
        diff = {{2{level[SAMPLE_W-1]}}, level} - {{2{thr[SAMPLE_W-1]}}, thr};
        return diff >= $signed({3'b000, margin});
    endfunction

endpackage

FILE: rtl/spcd_core.sv
// Cluster tracking: bin count, open cluster state and the results of each item.
module spcd_core #(
    parameter int FRAME_BINS = spcd_pkg::DEF_FRAME_BINS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  spcd_pkg::t_spcd_in    i_item,
    input  spcd_pkg::t_spcd_cfg   i_cfg,
    output spcd_pkg::t_spcd_push  o_push
);
    import spcd_pkg::*;

    localparam int CW = $clog2(FRAME_BINS);
    localparam int GW = (CW > GAP_W) ? CW : GAP_W;
    localparam logic [CW-1:0] LAST_BIN = CW'(FRAME_BINS - 1);

    logic [CW-1:0]              r_bin, n_bin;
    logic                       r_open, n_open;
    logic [CW-1:0]              r_start, n_start;
    logic [CW-1:0]              r_last, n_last;
    logic signed [SAMPLE_W-1:0] r_best_level, n_best_level;
    logic [CW-1:0]              r_best_bin, n_best_bin;

    logic signed [SAMPLE_W-1:0] level;
    logic signed [SAMPLE_W-1:0] thr;
    logic                       above;
    logic                       gap_break;
    logic                       frame_last;
    logic                       open_after;
    logic                       res_a;
    logic                       res_b;
    t_spcd_out                  out_a;
    t_spcd_out                  out_b;

    assign level      = i_item.sample_db;
    assign thr        = i_cfg.level_threshold;
    assign above      = level > thr;
    assign gap_break  = r_open && ((GW'(r_bin) - GW'(r_last)) > GW'(i_cfg.gap_bins));
    assign frame_last = i_item.frame_end || (r_bin >= LAST_BIN);

    // Update the cluster for this bin
    always_comb begin
        n_start      = r_start;
        n_last       = r_last;
        n_best_level = r_best_level;
        n_best_bin   = r_best_bin;
        open_after   = r_open;
        if (above) begin
            open_after = 1'b1;
            if (gap_break || !r_open) begin
                n_start      = r_bin;
                n_last       = r_bin;
                n_best_level = level;
                n_best_bin   = r_bin;
            end else begin
                n_last = r_bin;
                if (level > r_best_level) begin
                    n_best_level = level;
                    n_best_bin   = r_bin;
                end
            end
        end
        n_open = frame_last ? 1'b0 : open_after;
        n_bin  = frame_last ? '0 : r_bin + 1'b1;
    end

    // Build results: old cluster closed by a gap, then cluster closed by frame end
    always_comb begin
        res_a = above && gap_break &&
                margin_ok(r_best_level, thr, i_cfg.min_margin);
        res_b = frame_last && open_after &&
                margin_ok(n_best_level, thr, i_cfg.min_margin);

        out_a.peak_bin   = BIN_OUT_W'(r_best_bin);
        out_a.peak_level = r_best_level;
        out_a.first_bin  = BIN_OUT_W'(r_start);
        out_a.final_bin  = BIN_OUT_W'(r_last);
        out_a.run_last   = !res_b;

        out_b.peak_bin   = BIN_OUT_W'(n_best_bin);
        out_b.peak_level = n_best_level;
        out_b.first_bin  = BIN_OUT_W'(n_start);
        out_b.final_bin  = BIN_OUT_W'(n_last);
        out_b.run_last   = 1'b1;

        o_push.count = i_accept ? ({1'b0, res_a} + {1'b0, res_b}) : 2'd0;
        o_push.slot0 = res_a ? out_a : out_b;
        o_push.slot1 = out_b;
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin  <= '0;
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_bin  <= n_bin;
            r_open <= n_open;
        end
    end

    // Advance the cluster payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_start      <= n_start;
            r_last       <= n_last;
            r_best_level <= n_best_level;
            r_best_bin   <= n_best_bin;
        end
    end

endmodule

FILE: rtl/spcd_outq.sv
// Result queue: takes up to two items per cycle, delivers one per cycle unless stalled.
module spcd_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spcd_pkg::t_spcd_push  i_push,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_stall,
    output spcd_pkg::t_spcd_out   o_data
);
    import spcd_pkg::*;

    t_spcd_out            r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [OQ_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [OQ_CNT_W-1:0]  r_count, n_count;
    logic                 pop;
    logic [OQ_PTR_W-1:0]  wr_ptr_b;

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign pop      = o_valid && !i_stall;
    // Refuse new items unless two slots are free
    assign o_full   = (r_count > OQ_CNT_W'(OQ_DEPTH - 2));
    assign wr_ptr_b = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + OQ_PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + OQ_PTR_W'(pop);
        n_count  = r_count + OQ_CNT_W'(i_push.count) - OQ_CNT_W'(pop);
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write result slots
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.slot1;
        end
    end

endmodule

FILE: rtl/spectral_peak_cluster_detector.sv
// Top level: register port, cluster tracker and result queue.
// A result item enters the queue when the item that closes its cluster is accepted.
// Throughput: one item per cycle; a four-entry result queue absorbs the two results
// that one item can cause, and input stall rises while fewer than two entries are free.
// Reset: synchronous, active low; clears bin count, open flag and queue, loads register defaults.
module spectral_peak_cluster_detector #(
    parameter int FRAME_BINS = spcd_pkg::DEF_FRAME_BINS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  spcd_pkg::t_spcd_in                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output spcd_pkg::t_spcd_out                o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spcd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [spcd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spcd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import spcd_pkg::*;

    t_spcd_cfg  r_cfg;
    t_spcd_push push;
    logic       accept;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign accept  = i_in_valid && !o_in_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_threshold <= RST_LEVEL_THRESHOLD;
            r_cfg.gap_bins        <= RST_GAP_BINS;
            r_cfg.min_margin      <= RST_MIN_MARGIN;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LEVEL_THRESHOLD: r_cfg.level_threshold <= pwdata[SAMPLE_W-1:0];
                REG_GAP_BINS:        r_cfg.gap_bins        <= pwdata[GAP_W-1:0];
                REG_MIN_MARGIN:      r_cfg.min_margin      <= pwdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (reg_idx)
            REG_LEVEL_THRESHOLD: prdata = APB_DATA_W'($unsigned(r_cfg.level_threshold));
            REG_GAP_BINS:        prdata = APB_DATA_W'(r_cfg.gap_bins);
            REG_MIN_MARGIN:      prdata = APB_DATA_W'(r_cfg.min_margin);
            default:             prdata = '0;
        endcase
    end

    spcd_core #(
        .FRAME_BINS (FRAME_BINS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_push   (push)
    );

    spcd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
